>>> hw/rtl/rcrf_pkg.sv
// package for the rule-driven ring automaton random fraction block
// shared sizes, rule register reset value, cell control struct and sequencer states
// no dependencies
package rcrf_pkg;

    localparam int NUM_CELLS_DEF = 448;
    localparam int OUT_BITS_DEF  = 52;
    localparam int SEED_BITS_DEF = 64;

    localparam int          RULE_W     = 8;
    localparam logic [7:0]  RULE_RESET = 8'h1E;

    typedef struct packed {
        logic load;
        logic step;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

endpackage

>>> hw/rtl/rcrf_cell.sv
// one cell of the automaton ring: holds one bit, looks up its next value in the rule
// depends on rcrf_pkg (cell_ctrl_t, RULE_W)
module rcrf_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcrf_pkg::cell_ctrl_t          ctrl,
    input  logic [rcrf_pkg::RULE_W-1:0]   rule,
    input  logic                          left_bit,
    input  logic                          right_bit,
    input  logic                          seed_bit,
    output logic                          state_bit,
    output logic                          next_bit
);

    logic       cell_reg;
    logic       cell_next;
    logic [2:0] pattern;

    assign pattern  = {left_bit, cell_reg, right_bit};
    assign next_bit = rule[pattern];

    always_comb
    begin
        cell_next = cell_reg;
        if (ctrl.load)
        begin
            cell_next = seed_bit;
        end
        else if (ctrl.step)
        begin
            cell_next = next_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= 1'b0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign state_bit = cell_reg;

endmodule

>>> hw/rtl/rule30_ring_random_fraction.sv
// top level of the ring automaton random fraction generator: ring of cells, sequencer,
// result shift register, output register and rule register
// depends on rcrf_pkg and rcrf_cell
//
//  channel   signals                              payload
//  s_        s_tvalid s_tready s_tdata            seed
//  m_        m_tvalid m_tready m_tdata            random_fraction
//  cfg_      cfg_valid cfg_ready cfg_data         rule_number
//
// a request is accepted in idle and loads the ring unless its seed is zero, then one ring
// generation per cycle, all cells at once, unless held; OUT_BITS generations set the figure
// reset clears the ring to zero and sets the rule to 30; no clearing pass
// a waiting result does not block the next request; the last generation holds only while
// an earlier result still sits in the output register
module rule30_ring_random_fraction
#(
    parameter int NUM_CELLS = rcrf_pkg::NUM_CELLS_DEF,
    parameter int OUT_BITS  = rcrf_pkg::OUT_BITS_DEF,
    parameter int SEED_BITS = rcrf_pkg::SEED_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SEED_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // seed
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((OUT_BITS + 7) / 8) * 8 - 1:0]  m_tdata,   // random_fraction
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rcrf_pkg::RULE_W-1:0]           cfg_data    // rule_number
);

    localparam int OUT_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int CNT_W  = $clog2(OUT_BITS + 1);
    localparam int CENTRE = NUM_CELLS / 2;

    rcrf_pkg::seq_state_t          state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [OUT_BITS-1:0]           acc_reg, acc_next;
    logic [OUT_BITS-1:0]           out_data_reg, out_data_next;
    logic                          out_valid_reg, out_valid_next;
    logic [rcrf_pkg::RULE_W-1:0]   rule_reg, rule_next;

    logic [NUM_CELLS-1:0]          ring_q;
    logic [NUM_CELLS-1:0]          ring_d;
    rcrf_pkg::cell_ctrl_t          cell_ctrl;

    logic                          in_fire;
    logic                          seed_nonzero;
    logic                          last_gen;
    logic                          step_en;
    logic [OUT_BITS-1:0]           acc_shift;

    assign s_tready  = (state_reg == rcrf_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;

    assign seed_nonzero = (s_tdata[SEED_BITS-1:0] != '0);
    assign last_gen     = (cnt_reg == CNT_W'(OUT_BITS - 1));
    assign step_en      = (state_reg == rcrf_pkg::ST_RUN)
                          && !(last_gen && out_valid_reg && !m_tready);

    assign cell_ctrl.load = in_fire && seed_nonzero;
    assign cell_ctrl.step = step_en;

    // ring of cells, left neighbor is q+1 and right neighbor q-1, wrapping
    for (genvar q = 0; q < NUM_CELLS; q++)
    begin : g_cell
        localparam int LEFT  = (q + 1) % NUM_CELLS;
        localparam int RIGHT = (q + NUM_CELLS - 1) % NUM_CELLS;
        localparam int SBIT  = q % SEED_BITS;

        rcrf_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .rule      (rule_reg),
            .left_bit  (ring_q[LEFT]),
            .right_bit (ring_q[RIGHT]),
            .seed_bit  (s_tdata[SBIT]),
            .state_bit (ring_q[q]),
            .next_bit  (ring_d[q])
        );
    end

    assign acc_shift = OUT_BITS'({acc_reg, ring_d[CENTRE]});

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        rule_next      = rule_reg;

        if (cfg_valid && cfg_ready)
        begin
            rule_next = cfg_data;
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rcrf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = rcrf_pkg::ST_RUN;
                    cnt_next   = '0;
                    acc_next   = '0;
                end
            end
            rcrf_pkg::ST_RUN:
            begin
                if (step_en)
                begin
                    acc_next = acc_shift;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (last_gen)
                    begin
                        out_data_next  = acc_shift;
                        out_valid_next = 1'b1;
                        state_next     = rcrf_pkg::ST_IDLE;
                        cnt_next       = '0;
                    end
                end
            end
            default:
            begin
                state_next = rcrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcrf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            rule_reg      <= rcrf_pkg::RULE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            rule_reg      <= rule_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    a_result_from_run : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == rcrf_pkg::ST_RUN))
        else $error("result appeared without a finished run");

    a_request_starts_run : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == rcrf_pkg::ST_RUN) && (cnt_reg == '0))
        else $error("accepted request did not start a run");

    a_count_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(OUT_BITS))
        else $error("generation count out of range");

    a_no_lost_result : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(out_data_reg))
        else $error("pending result overwritten or dropped");

endmodule

>>> tb/sv/tb_rule30_ring_random_fraction.sv
`timescale 1ns / 1ps
// self-checking testbench for the ring automaton random fraction generator: seed requests
// in bursts, random output stalls, rule register changes between phases, in-bench predictor
// depends on rcrf_pkg and rule30_ring_random_fraction
module tb_rule30_ring_random_fraction;

    localparam int NCELLS = rcrf_pkg::NUM_CELLS_DEF;
    localparam int NBITS  = rcrf_pkg::OUT_BITS_DEF;
    localparam int SBITS  = rcrf_pkg::SEED_BITS_DEF;
    localparam int RW     = rcrf_pkg::RULE_W;
    localparam int SW     = ((SBITS + 7) / 8) * 8;
    localparam int MW     = ((NBITS + 7) / 8) * 8;
    localparam int CENTRE = NCELLS / 2;
    localparam int RX_HOLD_CYCLES = 600;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [SW-1:0]     s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [MW-1:0]     m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [RW-1:0]     cfg_data  = '0;

    // predictor state
    logic [NCELLS-1:0] ring_cells;
    logic [RW-1:0]     rule_reg;
    logic [NBITS-1:0]  predicted_fraction;

    logic [SBITS-1:0]  pending_seeds[$];
    logic [NBITS-1:0]  expected_fractions[$];

    int error_count    = 0;
    int accepted_count = 0;
    int zero_seed_count = 0;
    int result_count   = 0;
    int rule_writes    = 0;
    int burst_left     = 4;
    int gap_left       = 0;
    int rx_mode        = 0;
    int rx_mode_left   = 0;
    logic rx_hold      = 1'b0;
    logic rx_ready_next;

    rule30_ring_random_fraction dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 30)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // refill or continue the ring, then run the generations and collect centre bits
    task automatic run_automaton(input logic [SBITS-1:0] seed, output logic [NBITS-1:0] frac);
        logic [NCELLS-1:0] next_cells;
        logic [2:0]        pattern;
        int                left;
        int                right;
        frac = '0;
        if (seed != '0)
        begin
            for (int q = 0; q < NCELLS; q++)
                ring_cells[q] = seed[q % SBITS];
        end
        for (int g = 0; g < NBITS; g++)
        begin
            for (int q = 0; q < NCELLS; q++)
            begin
                left          = (q == NCELLS - 1) ? 0 : q + 1;
                right         = (q == 0) ? NCELLS - 1 : q - 1;
                pattern       = {ring_cells[left], ring_cells[q], ring_cells[right]};
                next_cells[q] = rule_reg[pattern];
            end
            ring_cells = next_cells;
            frac       = {frac[NBITS-2:0], ring_cells[CENTRE]};
        end
    endtask

    // driver: bursts of requests from the pending queue with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 4;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                run_automaton(s_tdata[SBITS-1:0], predicted_fraction);
                expected_fractions.push_back(predicted_fraction);
                accepted_count <= accepted_count + 1;
                if (s_tdata[SBITS-1:0] == '0)
                    zero_seed_count <= zero_seed_count + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_seeds.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= SW'(pending_seeds.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: stall pattern changes mode every so often, checks each result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_mode      <= 0;
            rx_mode_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_count <= result_count + 1;
                if (expected_fractions.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    predicted_fraction = expected_fractions.pop_front();
                    if (m_tdata !== {{(MW-NBITS){1'b0}}, predicted_fraction})
                        report_mismatch($sformatf("random_fraction got %h exp %h",
                                                  m_tdata, predicted_fraction));
                end
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(32, 256);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                0:       rx_ready_next = 1'b1;
                1:       rx_ready_next = ($urandom_range(0, 3) != 0);
                default: rx_ready_next = ($urandom_range(0, 3) == 0);
            endcase
            m_tready <= rx_ready_next && !rx_hold;
        end
    end

    // long receiver hold-off while the sender keeps offering requests
    initial
    begin
        while (accepted_count < 150)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic wait_idle();
        while (pending_seeds.size() != 0 || s_tvalid || expected_fractions.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_rule(input logic [RW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rule_reg   = value;
        cfg_valid <= 1'b0;
        rule_writes++;
    endtask

    function automatic logic [SBITS-1:0] pick_seed();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return {$urandom, $urandom};
        else if (sel < 80)
            return '0;
        else if (sel < 88)
            return SBITS'(1) << $urandom_range(0, SBITS - 1);
        else if (sel < 94)
            return ~(SBITS'(1) << $urandom_range(0, SBITS - 1));
        else
            return {$urandom & $urandom, $urandom & $urandom};
    endfunction

    initial
    begin
        logic [RW-1:0] phase_rules[8];
        ring_cells = '0;
        rule_reg   = rcrf_pkg::RULE_RESET;
        phase_rules = '{8'd30, 8'd110, 8'd90, RW'($urandom_range(0, 255)), 8'd150, 8'd45,
                        RW'($urandom_range(0, 255)), 8'd30};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rule, zero seed on the cleared ring first
        pending_seeds.push_back('0);
        pending_seeds.push_back('0);
        pending_seeds.push_back(64'h1);
        pending_seeds.push_back(64'h8000_0000_0000_0000);
        pending_seeds.push_back('1);
        pending_seeds.push_back('0);
        pending_seeds.push_back(64'h5555_5555_5555_5555);
        pending_seeds.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_seeds.push_back(64'h0000_0001_0000_0000);
        pending_seeds.push_back(64'h0000_0000_FFFF_FFFF);
        pending_seeds.push_back(64'hFFFF_FFFF_0000_0000);
        pending_seeds.push_back({$urandom, $urandom});
        pending_seeds.push_back('0);
        wait_idle();

        // extreme rules and a rule that flips an empty ring
        write_rule(8'd0);
        pending_seeds.push_back('1);
        pending_seeds.push_back('0);
        wait_idle();
        write_rule(8'd255);
        pending_seeds.push_back(64'h1);
        pending_seeds.push_back('0);
        wait_idle();
        write_rule(8'd1);
        pending_seeds.push_back(64'h8000_0000_0000_0001);
        pending_seeds.push_back('0);
        pending_seeds.push_back('0);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            write_rule(phase_rules[p]);
            for (int i = 0; i < 100; i++)
                pending_seeds.push_back(pick_seed());
            wait_idle();
        end

        repeat (NBITS + 16) @(posedge clk);
        while (expected_fractions.size() != 0)
        begin
            predicted_fraction = expected_fractions.pop_front();
            report_mismatch($sformatf("missing result, expected %h", predicted_fraction));
        end

        $display("run covered %0d seed requests (%0d zero-seed) under %0d rule writes",
                 accepted_count, zero_seed_count, rule_writes);
        $display("%0d results compared, %0d mismatches", result_count, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
